// ===== sv/mi3_pkg.sv =====
// Shared constants, types and width helpers for the 3x3 matrix inverse core.
`default_nettype none
package mi3_pkg;

	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	typedef struct packed {
		logic neg;
		logic ovf;
	} mi3_flags_t;

	function automatic int mi3_xw(input int w, input int f);
		int a;
		a = 2 * w + 2 * f;
		if (a < 3 * w + 2) begin
			a = 3 * w + 2;
		end
		return a + w + 2;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mi3_mat_if.sv =====
// Input channel: one matrix of nine signed fixed-point entries per beat.
`default_nettype none
interface mi3_mat_if #(
	parameter int W = mi3_pkg::ENTRY_WIDTH_DEF
) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (
		output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready
	);
	modport sink (
		input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/mi3_inv_if.sv =====
// Output channel: inverse entries, determinant and singular flag per beat.
`default_nettype none
interface mi3_inv_if #(
	parameter int W = mi3_pkg::ENTRY_WIDTH_DEF
) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [W-1:0] det_value;
	logic singular;

	modport source (
		output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, det_value, singular,
		input ready
	);
	modport sink (
		input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, det_value, singular,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/mi3_front.sv =====
// Front pipeline: cross products, exact determinant and divider operands.
`default_nettype none
module mi3_front #(
	parameter int W = mi3_pkg::ENTRY_WIDTH_DEF,
	parameter int F = mi3_pkg::FRAC_BITS_DEF,
	localparam int XW = mi3_pkg::mi3_xw(W, F)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vld,
	input  wire logic signed [W-1:0]   e [9],
	output logic                       vld_s6,
	output logic [XW-1:0]              n_s6 [9],
	output logic [XW-1:0]              dd_s6,
	output mi3_pkg::mi3_flags_t        flags_s6 [9],
	output logic [W-1:0]               det_s6,
	output logic                       sing_s6
);
	localparam int CW = 2 * W + 1;
	localparam int DW = 3 * W + 2;
	localparam int SH = 2 * F;
	localparam logic [DW:0] RND = ((DW + 1)'(1) << SH) >> 1;
	localparam logic [W-1:0] HALF = {1'b1, {(W - 1){1'b0}}};

	logic signed [2*W-1:0] pp_s1 [3][3];
	logic signed [2*W-1:0] pq_s1 [3][3];
	logic signed [W-1:0]   col_s1 [3];
	logic signed [CW-1:0]  cr_s2 [3][3];
	logic signed [W-1:0]   col_s2 [3];
	logic signed [CW-1:0]  cr_s3 [3][3];
	logic signed [2*W:0]   lo_s3 [3];
	logic signed [2*W:0]   hi_s3 [3];
	logic signed [CW-1:0]  cr_s4 [3][3];
	logic signed [DW-1:0]  d_s4;
	logic [CW-1:0]         nabs_s5 [9];
	logic                  neg_s5 [9];
	logic [DW-1:0]         dabs_s5;
	logic [DW:0]           tr_s5;
	logic                  dneg_s5;
	logic                  sing_s5;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                  big;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		localparam int U = (i == 0) ? 1 : ((i == 1) ? 2 : 0);
		localparam int V = (i == 0) ? 2 : ((i == 1) ? 0 : 1);
		for (genvar j = 0; j < 3; j++) begin : g_comp
			localparam int Y = (j + 1) % 3;
			localparam int Z = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s1[i][j] <= e[3*Y+U] * e[3*Z+V];
					pq_s1[i][j] <= e[3*Z+U] * e[3*Y+V];
					cr_s2[i][j] <= CW'(pp_s1[i][j]) - CW'(pq_s1[i][j]);
					cr_s3[i][j] <= cr_s2[i][j];
					cr_s4[i][j] <= cr_s3[i][j];
					nabs_s5[3*i+j] <= cr_s4[i][j][CW-1] ? CW'(-cr_s4[i][j]) : CW'(cr_s4[i][j]);
					neg_s5[3*i+j] <= cr_s4[i][j][CW-1] ^ d_s4[DW-1];
					n_s6[3*i+j] <= (XW'(nabs_s5[3*i+j]) << (SH + 1)) + XW'(dabs_s5);
					flags_s6[3*i+j].neg <= neg_s5[3*i+j];
					flags_s6[3*i+j].ovf <= ((XW'(nabs_s5[3*i+j]) << (SH + 1)) + XW'(dabs_s5))
						>= (XW'(dabs_s5) << (W + 1));
				end
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				col_s1[k] <= e[3*k+2];
				col_s2[k] <= col_s1[k];
				lo_s3[k]  <= $signed({1'b0, cr_s2[2][k][W-1:0]}) * col_s2[k];
				hi_s3[k]  <= $signed(cr_s2[2][k][CW-1:W]) * col_s2[k];
			end
		end
	end

	assign big = |tr_s5[DW:W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= (DW'(hi_s3[0]) << W) + DW'(lo_s3[0])
				+ (DW'(hi_s3[1]) << W) + DW'(lo_s3[1])
				+ (DW'(hi_s3[2]) << W) + DW'(lo_s3[2]);
			dabs_s5 <= d_s4[DW-1] ? DW'(-d_s4) : DW'(d_s4);
			tr_s5   <= ({1'b0, (d_s4[DW-1] ? DW'(-d_s4) : DW'(d_s4))} + RND) >> SH;
			dneg_s5 <= d_s4[DW-1];
			sing_s5 <= (d_s4 == '0);
			dd_s6   <= XW'(dabs_s5) << 1;
			sing_s6 <= sing_s5;
			if (dneg_s5) begin
				det_s6 <= big ? HALF : W'(-tr_s5[W-1:0]);
			end else begin
				det_s6 <= big ? ~HALF : tr_s5[W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/mi3_div_lane.sv =====
// One divider lane: pipelined restoring division, one quotient bit per stage.
`default_nettype none
module mi3_div_lane #(
	parameter int W = mi3_pkg::ENTRY_WIDTH_DEF,
	parameter int F = mi3_pkg::FRAC_BITS_DEF,
	localparam int XW = mi3_pkg::mi3_xw(W, F)
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [XW-1:0]        n,
	input  wire logic [XW-1:0]        dd,
	input  wire mi3_pkg::mi3_flags_t  flags,
	output logic [W-1:0]              q,
	output mi3_pkg::mi3_flags_t       flags_o
);
	logic [XW-1:0]       rem [W];
	logic [XW-1:0]       den [W];
	logic [W-1:0]        qq  [W+1];
	mi3_pkg::mi3_flags_t flg [W+1];

	assign rem[0] = n;
	assign den[0] = dd;
	assign qq[0]  = '0;
	assign flg[0] = flags;

	for (genvar g = 0; g < W; g++) begin : g_stage
		localparam int K = W - 1 - g;
		logic [XW-1:0] trial;
		logic          take;
		assign trial = den[g] << K;
		assign take  = rem[g] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				qq[g+1]  <= take ? (qq[g] | (W'(1) << K)) : qq[g];
				flg[g+1] <= flg[g];
			end
		end
		if (g < W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem[g+1] <= take ? rem[g] - trial : rem[g];
					den[g+1] <= den[g];
				end
			end
		end
	end

	assign q       = qq[W];
	assign flags_o = flg[W];
endmodule
`default_nettype wire

// ===== sv/mi3_merge.sv =====
// Merge stage: signs and saturates the lane quotients into the output register.
`default_nettype none
module mi3_merge #(
	parameter int W = mi3_pkg::ENTRY_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld,
	input  wire logic                 sing,
	input  wire logic [W-1:0]         det,
	input  wire logic [W-1:0]         q [9],
	input  wire mi3_pkg::mi3_flags_t  flags [9],
	output logic                      vld_q,
	output logic [W-1:0]              r_q [9],
	output logic [W-1:0]              det_q,
	output logic                      sing_q
);
	localparam logic [W-1:0] HALF = {1'b1, {(W - 1){1'b0}}};

	logic [W-1:0] sat [9];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			if (sing) begin
				sat[i] = '0;
			end else if (flags[i].ovf) begin
				sat[i] = flags[i].neg ? HALF : ~HALF;
			end else if (flags[i].neg) begin
				sat[i] = (q[i] > HALF) ? HALF : W'(-q[i]);
			end else begin
				sat[i] = (q[i] > ~HALF) ? ~HALF : q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q    <= sat;
			det_q  <= sing ? '0 : det;
			sing_q <= sing;
		end
	end
endmodule
`default_nettype wire

// ===== sv/matrix3_inverse_determinant_core.sv =====
// Top level of the 3x3 matrix inverse and determinant core.
// The mat channel takes one 3x3 matrix of signed fixed-point entries per beat;
// the inv channel returns one beat per matrix with the nine inverse entries,
// the determinant and a singular flag. Both use a valid/ready handshake.
// The datapath is a single pipeline: six front stages form the cross
// products and the exact determinant, nine divider lanes then produce one
// quotient bit per stage for ENTRY_WIDTH stages, and a merge stage saturates
// the results into the output register. A new matrix is accepted every
// cycle unless the receiver stalls with a beat waiting.
// A matrix whose exact determinant is zero returns zero entries, a zero
// determinant and singular set. Results saturate to the entry range.
// When the receiver stalls with a beat waiting, the whole pipeline holds and
// mat.ready falls in the same cycle; it rises again as soon as that beat is
// taken. Reset clears all valid bits, so no beat is presented after reset
// until a new matrix has gone through.
`default_nettype none
module matrix3_inverse_determinant_core #(
	parameter int ENTRY_WIDTH = mi3_pkg::ENTRY_WIDTH_DEF,
	parameter int FRAC_BITS   = mi3_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mi3_mat_if.sink  mat,
	mi3_inv_if.source inv
);
	localparam int W  = ENTRY_WIDTH;
	localparam int XW = mi3_pkg::mi3_xw(ENTRY_WIDTH, FRAC_BITS);

	logic                en;
	logic signed [W-1:0] e [9];
	logic                vld_s6;
	logic [XW-1:0]       n_s6 [9];
	logic [XW-1:0]       dd_s6;
	mi3_pkg::mi3_flags_t flags_s6 [9];
	logic [W-1:0]        det_s6;
	logic                sing_s6;
	logic [W-1:0]        q [9];
	mi3_pkg::mi3_flags_t qflags [9];
	logic [W-1:0]        vd_q;
	logic                sd_q [W+1];
	logic [W-1:0]        dt_q [W+1];
	logic                out_vld;
	logic [W-1:0]        r [9];
	logic [W-1:0]        det_out;
	logic                sing_out;

	assign en        = !out_vld || inv.ready;
	assign mat.ready = en;

	assign e[0] = mat.a00;
	assign e[1] = mat.a01;
	assign e[2] = mat.a02;
	assign e[3] = mat.a10;
	assign e[4] = mat.a11;
	assign e[5] = mat.a12;
	assign e[6] = mat.a20;
	assign e[7] = mat.a21;
	assign e[8] = mat.a22;

	mi3_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (mat.valid),
		.e        (e),
		.vld_s6   (vld_s6),
		.n_s6     (n_s6),
		.dd_s6    (dd_s6),
		.flags_s6 (flags_s6),
		.det_s6   (det_s6),
		.sing_s6  (sing_s6)
	);

	for (genvar i = 0; i < 9; i++) begin : g_lane
		mi3_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
			.clk     (clk),
			.en      (en),
			.n       (n_s6[i]),
			.dd      (dd_s6),
			.flags   (flags_s6[i]),
			.q       (q[i]),
			.flags_o (qflags[i])
		);
	end

	assign sd_q[0] = sing_s6;
	assign dt_q[0] = det_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_q <= '0;
		end else if (en) begin
			vd_q <= {vd_q[W-2:0], vld_s6};
		end
	end

	for (genvar g = 0; g < W; g++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sd_q[g+1] <= sd_q[g];
				dt_q[g+1] <= dt_q[g];
			end
		end
	end

	mi3_merge #(.W(W)) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (vd_q[W-1]),
		.sing   (sd_q[W]),
		.det    (dt_q[W]),
		.q      (q),
		.flags  (qflags),
		.vld_q  (out_vld),
		.r_q    (r),
		.det_q  (det_out),
		.sing_q (sing_out)
	);

	assign inv.valid     = out_vld;
	assign inv.r00       = r[0];
	assign inv.r01       = r[1];
	assign inv.r02       = r[2];
	assign inv.r10       = r[3];
	assign inv.r11       = r[4];
	assign inv.r12       = r[5];
	assign inv.r20       = r[6];
	assign inv.r21       = r[7];
	assign inv.r22       = r[8];
	assign inv.det_value = det_out;
	assign inv.singular  = sing_out;
endmodule
`default_nettype wire
